@@ hw/rtl/itrt_pkg.sv @@
// Shared types, constants and helpers for the integer to radix text unit.
// No dependencies; every module of the block imports this package.
package itrt_pkg;

  // Conversion modes carried on in_opcode
  localparam logic [1:0] OP_S32 = 2'd0;
  localparam logic [1:0] OP_U32 = 2'd1;
  localparam logic [1:0] OP_U64 = 2'd2;

  // Accepted range of bases
  localparam logic [5:0] RADIX_MIN = 6'd2;
  localparam logic [5:0] RADIX_MAX = 6'd35;

  // ASCII codes used by the emitter
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_A     = 7'h61;
  localparam logic [6:0] CHAR_MINUS = 7'h2d;
  localparam logic [6:0] CHAR_NONE  = 7'h00;

  // Quotient bits retired per divider cycle
  localparam int unsigned BITS_PER_STEP = 8;

  // One classified job as it travels from front to back
  typedef struct packed {
    logic        bad;     // base out of range
    logic        neg;     // emit a leading minus
    logic        mode32;  // magnitude fits in the low 32 bits
    logic [5:0]  radix;
    logic [63:0] mag;
  } job_t;

  // Map a digit value to its lower-case ASCII character
  function automatic logic [6:0] digit_char(input logic [5:0] d);
    logic [6:0] ch;
    if (d < 6'd10) begin
      ch = CHAR_ZERO + {1'b0, d};
    end else begin
      ch = CHAR_A + {1'b0, d} - 7'd10;
    end
    return ch;
  endfunction

endpackage

@@ hw/rtl/integer_to_radix_text_unit.sv @@
// Integer to radix text unit: an accepted job passes through the byte-per-cycle divider,
// which stores one digit at a time in the digit memory; characters then follow at one per
// cycle from the digit memory while the output is not stalled.
// A job with a bad base yields only an empty error beat; a two-entry queue takes new beats meanwhile.
// Synchronous active-low reset clears queue, sequencer and output valid; no clearing pass.
module integer_to_radix_text_unit
  import itrt_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [63:0] in_number,
  input  logic [5:0]  in_radix,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_character,
  output logic        out_final_res,
  output logic        out_bad_radix
);

  job_t front_job;
  job_t head_job;
  logic q_full;
  logic head_valid;
  logic head_pop;

  assign in_stall = q_full;

  // Classify incoming beats
  itrt_front u_front (
    .opcode (in_opcode),
    .number (in_number),
    .radix  (in_radix),
    .job    (front_job)
  );

  // Decouple front and back
  itrt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid),
    .push_job   (front_job),
    .full       (q_full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Divide and emit
  itrt_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (head_valid),
    .job           (head_job),
    .job_pop       (head_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_final_res (out_final_res),
    .out_bad_radix (out_bad_radix)
  );

endmodule

@@ hw/rtl/itrt_front.sv @@
// Front end: checks the base and forms the magnitude and sign of each input beat.
// Depends on itrt_pkg for job_t and the mode and range constants.
module itrt_front
  import itrt_pkg::*;
(
  input  logic [1:0]  opcode,
  input  logic [63:0] number,
  input  logic [5:0]  radix,
  output job_t        job
);

  logic [31:0] low;
  logic [31:0] low_neg;
  logic        is_signed;

  assign low       = number[31:0];
  assign low_neg   = ~low + 32'd1;
  assign is_signed = (opcode == OP_S32);

  // Classify the beat; negation of the most negative value wraps to its magnitude
  always_comb begin
    job.bad    = (radix < RADIX_MIN) || (radix > RADIX_MAX);
    job.radix  = radix;
    job.mode32 = (opcode == OP_S32) || (opcode == OP_U32);
    job.neg    = is_signed && low[31];
    if (is_signed && low[31]) begin
      job.mag = {32'd0, low_neg};
    end else if (job.mode32) begin
      job.mag = {32'd0, low};
    end else begin
      job.mag = number;
    end
  end

endmodule

@@ hw/rtl/itrt_queue.sv @@
// Two-entry job queue between the front end and the conversion engine.
// Depends on itrt_pkg for job_t.
module itrt_queue
  import itrt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_job   = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ hw/rtl/itrt_back.sv @@
// Conversion engine: radix-by-byte divider, digit memory and character emitter.
// Depends on itrt_pkg for job_t, character codes and digit_char.
module itrt_back
  import itrt_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_character,
  output logic       out_final_res,
  output logic       out_bad_radix
);

  localparam int unsigned IW = $clog2(MAX_DIGITS);
  localparam int unsigned CW = $clog2(MAX_DIGITS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_PRE  = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [63:0]   work_r, work_nxt;
  logic [5:0]    rem_r, rem_nxt;
  logic [5:0]    radix_r, radix_nxt;
  logic [2:0]    step_r, step_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          neg_r, neg_nxt;
  logic          mode32_r, mode32_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [6:0]    out_char_r, out_char_nxt;
  logic          out_final_r, out_final_nxt;
  logic          out_bad_r, out_bad_nxt;

  logic [5:0]    mem [MAX_DIGITS];
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [5:0]    rd_data_r;

  logic          slot_free;
  logic [7:0]    q_byte;
  logic [5:0]    rem_step;
  logic [63:0]   q_full;
  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] cnt_dec;

  assign slot_free = !out_valid_r || !out_stall;
  assign cnt_inc   = cnt_r + CW'(1);
  assign cnt_dec   = cnt_r - CW'(1);

  // Retire one byte of quotient bits against the current remainder
  always_comb begin
    logic [6:0] r;
    r      = '0;
    q_byte = '0;
    rem_step = rem_r;
    for (int b = 0; b < BITS_PER_STEP; b++) begin
      r = {rem_step, work_r[63 - b]};
      if (r >= {1'b0, radix_r}) begin
        r = r - {1'b0, radix_r};
        q_byte[BITS_PER_STEP - 1 - b] = 1'b1;
      end
      rem_step = r[5:0];
    end
  end

  // Full quotient at the end of a digit
  always_comb begin
    q_full = {work_r[55:0], q_byte};
    if (mode32_r) begin
      q_full = {32'd0, q_full[31:0]};
    end
  end

  // Sequence an error beat, or division followed by sign and digits
  always_comb begin
    state_nxt     = state_r;
    work_nxt      = work_r;
    rem_nxt       = rem_r;
    radix_nxt     = radix_r;
    step_nxt      = step_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    neg_nxt       = neg_r;
    mode32_nxt    = mode32_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_final_nxt = out_final_r;
    out_bad_nxt   = out_bad_r;
    job_pop       = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = cnt_r[IW-1:0];
    rd_en         = 1'b0;
    rd_addr       = idx_r;

    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          if (job.bad) begin
            if (slot_free) begin
              job_pop       = 1'b1;
              out_valid_nxt = 1'b1;
              out_char_nxt  = CHAR_NONE;
              out_final_nxt = 1'b1;
              out_bad_nxt   = 1'b1;
            end
          end else begin
            job_pop    = 1'b1;
            work_nxt   = job.mode32 ? {job.mag[31:0], 32'd0} : job.mag;
            rem_nxt    = '0;
            radix_nxt  = job.radix;
            step_nxt   = '0;
            cnt_nxt    = '0;
            neg_nxt    = job.neg;
            mode32_nxt = job.mode32;
            state_nxt  = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (step_r != (mode32_r ? 3'd3 : 3'd7)) begin
          work_nxt = {work_r[55:0], q_byte};
          rem_nxt  = rem_step;
          step_nxt = step_r + 3'd1;
        end else begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_inc;
          if ((q_full == 64'd0) || (cnt_inc == CW'(MAX_DIGITS))) begin
            state_nxt = ST_PRE;
          end else begin
            work_nxt = mode32_r ? {q_full[31:0], 32'd0} : q_full;
            rem_nxt  = '0;
            step_nxt = '0;
          end
        end
      end
      ST_PRE: begin
        rd_en     = 1'b1;
        rd_addr   = cnt_dec[IW-1:0];
        idx_nxt   = cnt_dec[IW-1:0];
        state_nxt = neg_r ? ST_SIGN : ST_EMIT;
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_final_nxt = 1'b0;
          out_bad_nxt   = 1'b0;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_char(rd_data_r);
          out_final_nxt = (idx_r == '0);
          out_bad_nxt   = 1'b0;
          if (idx_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r - IW'(1);
            rd_en   = 1'b1;
            rd_addr = idx_r - IW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath and output payload
  always_ff @(posedge clk) begin
    work_r      <= work_nxt;
    rem_r       <= rem_nxt;
    radix_r     <= radix_nxt;
    step_r      <= step_nxt;
    idx_r       <= idx_nxt;
    neg_r       <= neg_nxt;
    mode32_r    <= mode32_nxt;
    out_char_r  <= out_char_nxt;
    out_final_r <= out_final_nxt;
    out_bad_r   <= out_bad_nxt;
  end

  // Digit memory, least significant digit at address zero
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= rem_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_final_res = out_final_r;
  assign out_bad_radix = out_bad_r;

`ifndef ASSERT_OFF
  // A job leaves the queue only when the engine is idle and a job is there
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> (state_r == ST_IDLE) && job_valid)
    else $error("job popped outside idle");

  // The running remainder stays below the base
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < radix_r))
    else $error("remainder not below base");

  // The digit count never passes the store depth
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_DIGITS))
    else $error("digit count overflow");

  // An error beat is always the empty final result
  a_bad_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |-> (out_final_r && (out_char_r == CHAR_NONE)))
    else $error("malformed error beat");

  // A stalled beat is held, not dropped, while the engine divides
  a_hold_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && out_valid_r && out_stall |=> out_valid_r)
    else $error("result dropped during division");
`endif

endmodule
